>>> hdl/ggpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggpc_pkg
// Shared constants, types and the CORDIC angle table of the go-to-goal
// pose controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int XW            = 35;   // CORDIC x/y width
	localparam int ZW            = 34;   // CORDIC angle width, Q.30
	localparam int LATENCY       = CORDIC_STAGES + 5;

	localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
	localparam logic signed [16:0]   PI_Q13     = 17'sd25736;
	localparam logic signed [16:0]   TWO_PI_Q13 = 17'sd51472;
	localparam logic        [16:0]   SPEED_ONE  = 17'd65536;

	typedef enum logic [1:0] {
		MODE_STOP    = 2'd0,
		MODE_MOVING  = 2'd1,
		MODE_ORIENT  = 2'd2,
		MODE_REACHED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_LINEAR_GAIN   = 2'd0,
		CFG_ANGULAR_GAIN  = 2'd1,
		CFG_POSITION_TOL  = 2'd2,
		CFG_ANGLE_TOL     = 2'd3
	} cfg_index_t;

	// data that rides beside the CORDIC
	typedef struct packed {
		logic               pose_ok;
		logic               near;
		logic signed [16:0] yaw;
		logic        [16:0] lin;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/ggpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggpc_front
// Two stages: squares and gain product, then distance test, yaw wrap result
// and CORDIC preload.
// ----------------------------------------------------------------------------
module ggpc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [31:0]           goal_dx,
	input  wire logic signed [31:0]           goal_dy,
	input  wire logic signed [15:0]           goal_yaw_error,
	input  wire logic                         pose_valid,
	input  wire logic        [20:0]           linear_gain,
	input  wire logic        [20:0]           pos_tol,
	output logic                              out_valid,
	output logic signed [ggpc_pkg::XW-1:0]    x_out,
	output logic signed [ggpc_pkg::XW-1:0]    y_out,
	output logic signed [ggpc_pkg::ZW-1:0]    z_out,
	output ggpc_pkg::side_t                   side_out
);

	logic [31:0] ax, ay;
	logic [30:0] dxp;
	logic [21:0] tol_p1;
	logic signed [16:0] yaw_ext, yaw_w;

	logic               v_s1, pv_s1;
	logic signed [31:0] dx_s1, dy_s1;
	logic [63:0]        sqx_s1, sqy_s1;
	logic [43:0]        tsq_s1;
	logic [51:0]        linp_s1;
	logic signed [16:0] yaw_s1;

	logic signed [ggpc_pkg::XW-1:0] xe, ye;
	logic [63:0] dsq;
	logic [35:0] lin_full;
	logic [16:0] lin_c;

	always_comb begin
		ax      = goal_dx[31] ? (~goal_dx + 32'd1) : goal_dx;
		ay      = goal_dy[31] ? (~goal_dy + 32'd1) : goal_dy;
		dxp     = goal_dx[31] ? 31'd0 : goal_dx[30:0];
		tol_p1  = {1'b0, pos_tol} + 22'd1;
		yaw_ext = {goal_yaw_error[15], goal_yaw_error};
		if (yaw_ext > ggpc_pkg::PI_Q13) begin
			yaw_w = yaw_ext - ggpc_pkg::TWO_PI_Q13;
		end else if (yaw_ext < -ggpc_pkg::PI_Q13) begin
			yaw_w = yaw_ext + ggpc_pkg::TWO_PI_Q13;
		end else begin
			yaw_w = yaw_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pv_s1   <= pose_valid;
		dx_s1   <= goal_dx;
		dy_s1   <= goal_dy;
		sqx_s1  <= 64'(ax) * 64'(ax);
		sqy_s1  <= 64'(ay) * 64'(ay);
		tsq_s1  <= 44'(tol_p1) * 44'(tol_p1);
		linp_s1 <= 52'(linear_gain) * 52'(dxp);
		yaw_s1  <= yaw_w;
	end

	// floor(sqrt(n)) <= tol  exactly when  n < (tol+1)^2
	always_comb begin
		xe       = {{(ggpc_pkg::XW-32){dx_s1[31]}}, dx_s1};
		ye       = {{(ggpc_pkg::XW-32){dy_s1[31]}}, dy_s1};
		dsq      = sqx_s1 + sqy_s1;
		lin_full = linp_s1[51:16];
		lin_c    = (lin_full > 36'(ggpc_pkg::SPEED_ONE)) ? ggpc_pkg::SPEED_ONE
		                                                 : lin_full[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dx_s1[31]) begin
			x_out <= -xe;
			y_out <= -ye;
			z_out <= dy_s1[31] ? -ggpc_pkg::PI_Q30 : ggpc_pkg::PI_Q30;
		end else begin
			x_out <= xe;
			y_out <= ye;
			z_out <= '0;
		end
		side_out.pose_ok <= pv_s1;
		side_out.near    <= dsq < 64'(tsq_s1);
		side_out.yaw     <= yaw_s1;
		side_out.lin     <= lin_c;
	end

endmodule
`default_nettype wire

>>> hdl/ggpc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggpc_cordic
// Vectoring CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module ggpc_cordic (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [ggpc_pkg::XW-1:0] x_in,
	input  wire logic signed [ggpc_pkg::XW-1:0] y_in,
	input  wire logic signed [ggpc_pkg::ZW-1:0] z_in,
	input  wire ggpc_pkg::side_t              side_in,
	output logic                              out_valid,
	output logic signed [ggpc_pkg::ZW-1:0]    z_out,
	output ggpc_pkg::side_t                   side_out
);

	localparam int N = ggpc_pkg::CORDIC_STAGES;

	logic                           v_s  [N+1];
	logic signed [ggpc_pkg::XW-1:0] x_s  [N+1];
	logic signed [ggpc_pkg::XW-1:0] y_s  [N+1];
	logic signed [ggpc_pkg::ZW-1:0] z_s  [N+1];
	ggpc_pkg::side_t                sd_s [N+1];

	assign v_s[0]  = in_valid;
	assign x_s[0]  = x_in;
	assign y_s[0]  = y_in;
	assign z_s[0]  = z_in;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// rotate toward y = 0
		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ggpc_pkg::atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ggpc_pkg::atan_q30(i);
			end
			sd_s[i+1] <= sd_s[i];
		end
	end

	assign out_valid = v_s[N];
	assign z_out     = z_s[N];
	assign side_out  = sd_s[N];

endmodule
`default_nettype wire

>>> hdl/ggpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ggpc_back
// Mode decision, turn-rate multiply and clamp, three stages.
// ----------------------------------------------------------------------------
module ggpc_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [ggpc_pkg::ZW-1:0] z_in,
	input  wire ggpc_pkg::side_t              side_in,
	input  wire logic        [20:0]           angular_gain,
	input  wire logic        [14:0]           yaw_tol,
	output logic                              done,
	output logic        [16:0]                linear_speed,
	output logic signed [17:0]                angular_speed,
	output logic        [1:0]                 control_mode,
	output logic                              at_goal
);

	logic signed [ggpc_pkg::ZW-1:0] zr;
	logic signed [16:0] bearing;
	logic        [16:0] ayaw;
	ggpc_pkg::mode_t    mode;

	logic               v_s1, v_s2;
	ggpc_pkg::mode_t    mode_s1, mode_s2;
	logic signed [16:0] ang_s1;
	logic        [16:0] lin_s1, lin_s2;
	logic signed [38:0] prod_s2;

	logic signed [38:0] turn;
	logic signed [17:0] turn_c;

	always_comb begin
		zr      = (z_in + ggpc_pkg::ZW'(65536)) >>> 17;
		bearing = zr[16:0];
		ayaw    = side_in.yaw[16] ? 17'(-side_in.yaw) : side_in.yaw;
		if (!side_in.pose_ok) begin
			mode = ggpc_pkg::MODE_STOP;
		end else if (!side_in.near) begin
			mode = ggpc_pkg::MODE_MOVING;
		end else if (ayaw > 17'(yaw_tol)) begin
			mode = ggpc_pkg::MODE_ORIENT;
		end else begin
			mode = ggpc_pkg::MODE_REACHED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		unique case (mode)
			ggpc_pkg::MODE_MOVING: ang_s1 <= bearing;
			ggpc_pkg::MODE_ORIENT: ang_s1 <= side_in.yaw;
			default:               ang_s1 <= '0;
		endcase
		lin_s1 <= (mode == ggpc_pkg::MODE_MOVING) ? side_in.lin : '0;

		mode_s2 <= mode_s1;
		lin_s2  <= lin_s1;
		prod_s2 <= $signed({18'd0, angular_gain}) * 39'(ang_s1);
	end

	always_comb begin
		turn = prod_s2 >>> 13;
		if (turn > 39'sd65536) begin
			turn_c = 18'sd65536;
		end else if (turn < -39'sd65536) begin
			turn_c = -18'sd65536;
		end else begin
			turn_c = turn[17:0];
		end
	end

	always_ff @(posedge clk) begin
		linear_speed  <= lin_s2;
		angular_speed <= turn_c;
		control_mode  <= mode_s2;
		at_goal       <= (mode_s2 == ggpc_pkg::MODE_REACHED);
	end

	a_reached: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (at_goal == (control_mode == ggpc_pkg::MODE_REACHED)))
		else $error("goal flag disagrees with mode");
	a_lin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && control_mode != ggpc_pkg::MODE_MOVING) |-> (linear_speed == 17'd0))
		else $error("linear speed outside moving mode");
	a_ang_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (control_mode == ggpc_pkg::MODE_STOP ||
		          control_mode == ggpc_pkg::MODE_REACHED)) |-> (angular_speed == 18'sd0))
		else $error("turn rate while stopped");

endmodule
`default_nettype wire

>>> hdl/go_to_goal_pose_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller
// Proportional go-to-goal controller: distance test, CORDIC bearing, yaw
// wrap and clamped speed commands, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     goal_dx, goal_dy, goal_yaw_error, pose_valid
//  result    done (strobe)    linear_speed, angular_speed, control_mode,
//                             at_goal
//  config    cfg_we           cfg_index, cfg_wdata
//
//  One word enters per cycle; busy stays low. Each result passes through
//  two front stages, one CORDIC stage per micro-rotation and three back
//  stages. Reset clears the valid bits and loads the default gains and
//  tolerances. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] goal_dx,
	input  wire logic signed [31:0] goal_dy,
	input  wire logic signed [15:0] goal_yaw_error,
	input  wire logic               pose_valid,
	output logic                    done,
	output logic        [16:0]      linear_speed,
	output logic signed [17:0]      angular_speed,
	output logic        [1:0]       control_mode,
	output logic                    at_goal,
	input  wire logic               cfg_we,
	input  wire logic   [1:0]       cfg_index,
	input  wire logic   [20:0]      cfg_wdata
);

	logic [20:0] linear_gain_q, angular_gain_q, pos_tol_q;
	logic [14:0] yaw_tol_q;

	logic                           fv, cv;
	logic signed [ggpc_pkg::XW-1:0] fx, fy;
	logic signed [ggpc_pkg::ZW-1:0] fz, cz;
	ggpc_pkg::side_t                fside, cside;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_gain_q  <= 21'd32768;
			angular_gain_q <= 21'd32768;
			pos_tol_q      <= 21'd3277;
			yaw_tol_q      <= 15'd82;
		end else if (cfg_we) begin
			unique case (ggpc_pkg::cfg_index_t'(cfg_index))
				ggpc_pkg::CFG_LINEAR_GAIN:  linear_gain_q  <= cfg_wdata;
				ggpc_pkg::CFG_ANGULAR_GAIN: angular_gain_q <= cfg_wdata;
				ggpc_pkg::CFG_POSITION_TOL: pos_tol_q      <= cfg_wdata;
				ggpc_pkg::CFG_ANGLE_TOL:    yaw_tol_q      <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	ggpc_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (start && !busy),
		.goal_dx            (goal_dx),
		.goal_dy            (goal_dy),
		.goal_yaw_error     (goal_yaw_error),
		.pose_valid         (pose_valid),
		.linear_gain        (linear_gain_q),
		.pos_tol            (pos_tol_q),
		.out_valid          (fv),
		.x_out              (fx),
		.y_out              (fy),
		.z_out              (fz),
		.side_out           (fside)
	);

	ggpc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fv),
		.x_in      (fx),
		.y_in      (fy),
		.z_in      (fz),
		.side_in   (fside),
		.out_valid (cv),
		.z_out     (cz),
		.side_out  (cside)
	);

	ggpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (cv),
		.z_in            (cz),
		.side_in         (cside),
		.angular_gain    (angular_gain_q),
		.yaw_tol         (yaw_tol_q),
		.done            (done),
		.linear_speed    (linear_speed),
		.angular_speed   (angular_speed),
		.control_mode    (control_mode),
		.at_goal         (at_goal)
	);

endmodule
`default_nettype wire

>>> tb/sv/go_to_goal_pose_controller_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller_chk
// Watches the command, result and register channels of the go-to-goal
// controller, predicts every speed command and compares it field by field.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller_chk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [31:0] goal_dx,
	input  wire logic signed [31:0] goal_dy,
	input  wire logic signed [15:0] goal_yaw_error,
	input  wire logic               pose_valid,
	input  wire logic               done,
	input  wire logic        [16:0] linear_speed,
	input  wire logic signed [17:0] angular_speed,
	input  wire logic        [1:0]  control_mode,
	input  wire logic               at_goal,
	input  wire logic               cfg_we,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [20:0] cfg_wdata,
	output int                      errors,
	output int                      pending
);

	typedef struct {
		logic        [16:0] lin;
		logic signed [17:0] ang;
		ggpc_pkg::mode_t    mode;
		logic               reached;
	} cmd_t;

	localparam longint BEARING_STEP [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048575, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};
	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam longint UNIT_SPEED    = 65536;

	logic [20:0] lin_gain, ang_gain, pos_tol;
	logic [14:0] yaw_tol;
	cmd_t        cmd_q[$];

	function automatic logic [63:0] int_root(input logic [63:0] n);
		logic [63:0] res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint heading_q13(input longint x, input longint y);
		longint z, xs, ys;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < ggpc_pkg::CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + BEARING_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - BEARING_STEP[i];
			end
		end
		return (z + 65536) >>> 17;
	endfunction

	function automatic longint turn_rate(input longint ang_q13);
		longint v;
		v = (longint'(ang_gain) * ang_q13) >>> 13;
		if (v > UNIT_SPEED)
			v = UNIT_SPEED;
		if (v < -UNIT_SPEED)
			v = -UNIT_SPEED;
		return v;
	endfunction

	function automatic cmd_t predict_cmd(input longint dx, input longint dy,
		input longint yaw, input logic ok);
		cmd_t        c;
		longint      lin, ang, ax, ay, ayaw;
		logic [63:0] root_len;
		lin       = 0;
		ang       = 0;
		c.reached = 1'b0;
		if (!ok) begin
			c.mode = ggpc_pkg::MODE_STOP;
		end else begin
			ax       = dx < 0 ? -dx : dx;
			ay       = dy < 0 ? -dy : dy;
			root_len = int_root(64'(ax * ax) + 64'(ay * ay));
			if (root_len > 64'(pos_tol)) begin
				c.mode = ggpc_pkg::MODE_MOVING;
				if (dx > 0) begin
					lin = (longint'(lin_gain) * dx) >>> 16;
					if (lin > UNIT_SPEED)
						lin = UNIT_SPEED;
				end
				ang = turn_rate(heading_q13(dx, dy));
			end else begin
				if (yaw > 25736)
					yaw = yaw - 51472;
				else if (yaw < -25736)
					yaw = yaw + 51472;
				ayaw = yaw < 0 ? -yaw : yaw;
				if (ayaw > longint'(yaw_tol)) begin
					c.mode = ggpc_pkg::MODE_ORIENT;
					ang    = turn_rate(yaw);
				end else begin
					c.mode    = ggpc_pkg::MODE_REACHED;
					c.reached = 1'b1;
				end
			end
		end
		c.lin = lin[16:0];
		c.ang = ang[17:0];
		return c;
	endfunction

	assign pending = cmd_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain <= 21'd32768;
			ang_gain <= 21'd32768;
			pos_tol  <= 21'd3277;
			yaw_tol  <= 15'd82;
		end else if (cfg_we) begin
			unique case (ggpc_pkg::cfg_index_t'(cfg_index))
				ggpc_pkg::CFG_LINEAR_GAIN:  lin_gain <= cfg_wdata;
				ggpc_pkg::CFG_ANGULAR_GAIN: ang_gain <= cfg_wdata;
				ggpc_pkg::CFG_POSITION_TOL: pos_tol  <= cfg_wdata;
				ggpc_pkg::CFG_ANGLE_TOL:    yaw_tol  <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cmd_t want;
		if (!arst_n) begin
			errors = 0;
		end else begin
			if (start && !busy)
				cmd_q.push_back(predict_cmd(goal_dx, goal_dy, goal_yaw_error,
					pose_valid));
			if (done) begin
				if (cmd_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("%0t: result word with nothing expected", $realtime);
				end else begin
					want = cmd_q.pop_front();
					if (want.lin !== linear_speed || want.ang !== angular_speed ||
						want.mode !== control_mode || want.reached !== at_goal) begin
						errors = errors + 1;
						if (errors <= 10)
							$display({"%0t: exp lin %0d ang %0d mode %0d reached %0b,",
								" got %0d %0d %0d %0b"},
								$realtime, want.lin, want.ang, want.mode, want.reached,
								linear_speed, angular_speed, control_mode, at_goal);
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/go_to_goal_pose_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller_tb
// Drives goal poses and register settings into the controller, with random
// gaps, and lets the checker compare every speed command.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk, arst_n, start, busy, pose_valid, done, at_goal;
	logic signed [31:0] goal_dx, goal_dy;
	logic signed [15:0] goal_yaw_error;
	logic        [16:0] linear_speed;
	logic signed [17:0] angular_speed;
	logic        [1:0]  control_mode, cfg_index;
	logic               cfg_we;
	logic        [20:0] cfg_wdata;
	int                 errors, pending;
	int                 cycles = 0;
	logic        [20:0] tol_now;
	logic        [14:0] yaw_tol_now;
	bit                 no_gaps;

	go_to_goal_pose_controller u_dut (.*);
	go_to_goal_pose_controller_chk u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_word(input logic signed [31:0] dx, input logic signed [31:0] dy,
		input logic signed [15:0] yaw, input logic ok);
		int gap;
		goal_dx        <= dx;
		goal_dy        <= dy;
		goal_yaw_error <= yaw;
		pose_valid     <= ok;
		start          <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (!no_gaps) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				9:             gap = $urandom_range(10, 40);
				default:       gap = $urandom_range(1, 3);
			endcase
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input ggpc_pkg::cfg_index_t idx, input logic [20:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// hold until the pipe has drained
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (ggpc_pkg::LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_regs(input logic [20:0] lg, input logic [20:0] ag,
		input logic [20:0] pt, input logic [14:0] at);
		write_reg(ggpc_pkg::CFG_LINEAR_GAIN, lg);
		write_reg(ggpc_pkg::CFG_ANGULAR_GAIN, ag);
		write_reg(ggpc_pkg::CFG_POSITION_TOL, pt);
		write_reg(ggpc_pkg::CFG_ANGLE_TOL, 21'(at));
		cfg_we      <= 1'b0;
		tol_now     = pt;
		yaw_tol_now = at;
		@(posedge clk);
	endtask

	task automatic random_words(input int n);
		logic signed [31:0] dx, dy;
		logic signed [15:0] yaw;
		int                 span;
		for (int k = 0; k < n; k++) begin
			span = int'(tol_now);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// close to the goal on each axis: mostly orient or reached
					dx  = $urandom_range(0, 2 * span) - span;
					dy  = $urandom_range(0, 2 * span) - span;
					yaw = (int'(yaw_tol_now) + 2 >= 0 && $urandom_range(0, 1)) ?
						16'($urandom_range(0, 2 * yaw_tol_now + 4) - yaw_tol_now - 2) :
						16'($urandom);
				end
				3, 4, 5: begin
					dx  = $urandom_range(0, 400000) - 200000;
					dy  = $urandom_range(0, 400000) - 200000;
					yaw = 16'($urandom);
				end
				default: begin
					dx  = $urandom;
					dy  = $urandom;
					yaw = 16'($urandom);
				end
			endcase
			send_word(dx, dy, yaw, $urandom_range(0, 9) != 0);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		no_gaps        = 1'b0;
		start          = 1'b0;
		goal_dx        = '0;
		goal_dy        = '0;
		goal_yaw_error = '0;
		pose_valid     = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = ggpc_pkg::CFG_LINEAR_GAIN;
		cfg_wdata      = '0;
		tol_now        = 21'd3277;
		yaw_tol_now    = 15'd82;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: special cases and field extremes
		send_word(32'sd65536, 32'sd0, 16'sd0, 1'b0);
		send_word(32'sd0, 32'sd0, 16'sd0, 1'b1);
		send_word(32'sd0, 32'sd0, 16'sd82, 1'b1);
		send_word(32'sd0, 32'sd0, -16'sd83, 1'b1);
		send_word(32'sd0, 32'sd0, 16'sd32767, 1'b1);
		send_word(32'sd0, 32'sd0, -16'sd32768, 1'b1);
		send_word(32'sd0, 32'sd0, 16'sd25736, 1'b1);
		send_word(32'sd0, 32'sd0, 16'sd25737, 1'b1);
		send_word(32'sd0, 32'sd0, -16'sd25737, 1'b1);
		send_word(32'sd3277, 32'sd0, 16'sd0, 1'b1);
		send_word(32'sd3278, 32'sd0, 16'sd0, 1'b1);
		send_word(32'sd2147483647, 32'sd2147483647, 16'sd0, 1'b1);
		send_word(-32'sd2147483648, -32'sd2147483648, 16'sd0, 1'b1);
		send_word(-32'sd2147483648, 32'sd0, 16'sd0, 1'b1);
		send_word(-32'sd65536, -32'sd1, 16'sd0, 1'b1);
		send_word(32'sd0, 32'sd65536, 16'sd0, 1'b1);
		send_word(32'sd0, -32'sd65536, 16'sd0, 1'b1);
		send_word(-32'sd100000, 32'sd50000, 16'sd0, 1'b1);
		send_word(32'sd200000, -32'sd10, -16'sd1, 1'b1);
		drain();

		no_gaps = 1'b1;
		random_words(250);
		no_gaps = 1'b0;
		drain();
		set_regs(21'd0, 21'd0, 21'd0, 15'd0);
		send_word(32'sd0, 32'sd0, 16'sd0, 1'b1);
		send_word(32'sd0, 32'sd1, 16'sd1, 1'b1);
		random_words(230);
		drain();
		set_regs(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 15'h7FFF);
		random_words(250);
		drain();
		set_regs(21'd1048576, 21'd1048576, 21'd1048576, 15'd25736);
		random_words(250);
		drain();
		for (int p = 0; p < 3; p++) begin
			set_regs(21'($urandom), 21'($urandom_range(0, 200000)),
				21'($urandom_range(0, 300000)), 15'($urandom_range(0, 2000)));
			random_words(250);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> go_to_goal_pose_controller.f
hdl/ggpc_pkg.sv
hdl/ggpc_front.sv
hdl/ggpc_cordic.sv
hdl/ggpc_back.sv
hdl/go_to_goal_pose_controller.sv
tb/sv/go_to_goal_pose_controller_chk.sv
tb/sv/go_to_goal_pose_controller_tb.sv
